>>> sv/hsbm_pkg.sv
// hsbm_pkg: shared constants, command codes and controller/datapath structs
// for the host substring blocklist matcher; no dependencies
`default_nettype none

package hsbm_pkg;

  localparam int NUM_PATTERNS    = 16;
  localparam int MAX_PATTERN_LEN = 64;

  // field widths fixed by the item format
  localparam int CMD_W   = 2;
  localparam int SLOT_W  = 4;
  localparam int POS_W   = 6;
  localparam int BYTE_W  = 8;
  localparam int CNT_W   = 5;

  // derived widths
  localparam int LEN_W   = $clog2(MAX_PATTERN_LEN + 1);
  localparam int ROW_W   = MAX_PATTERN_LEN * BYTE_W;

  // item command codes
  localparam logic [CMD_W-1:0] CMD_WR_BYTE   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SET_LEN   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_HOST_BYTE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_END_HOST  = 2'd3;

  // controller -> datapath commands
  typedef struct packed {
    logic              wr_byte;
    logic              wr_len;
    logic              host_byte;
    logic              end_host;
    logic              issue;
    logic [SLOT_W-1:0] slot;
  } dp_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic [CNT_W-1:0] active_n;
  } dp_sts_t;

endpackage

`default_nettype wire

>>> sv/hsbm_if.sv
// hsbm_in_if / hsbm_out_if: valid/ready stream channels for input items
// and results; depends on hsbm_pkg
`default_nettype none

interface hsbm_in_if;
  import hsbm_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [SLOT_W-1:0] pattern_slot;
  logic [POS_W-1:0]  char_position;
  logic [BYTE_W-1:0] value;

  modport source (output valid, command, pattern_slot, char_position, value,
                  input ready);
  modport sink   (input valid, command, pattern_slot, char_position, value,
                  output ready);
endinterface

interface hsbm_out_if;
  logic valid;
  logic ready;
  logic blocked;

  modport source (output valid, blocked, input ready);
  modport sink   (input valid, blocked, output ready);
endinterface

`default_nettype wire

>>> sv/hsbm_datapath.sv
// hsbm_datapath: pattern memory, lengths, host window, slot compare pipe,
// match flag and result register; depends on hsbm_pkg
`default_nettype none

module hsbm_datapath (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire hsbm_pkg::dp_cmd_t       cmd,
  output hsbm_pkg::dp_sts_t            sts,
  input  wire logic                    cfg_wr_en,
  input  wire logic [hsbm_pkg::CNT_W-1:0]  cfg_wr_data,
  input  wire logic [hsbm_pkg::SLOT_W-1:0] pattern_slot,
  input  wire logic [hsbm_pkg::POS_W-1:0]  char_position,
  input  wire logic [hsbm_pkg::BYTE_W-1:0] value,
  output logic                         blocked
);
  import hsbm_pkg::*;

  // one row per slot, byte k of the pattern in lane k
  logic [ROW_W-1:0] pat_mem [NUM_PATTERNS];
  logic [LEN_W-1:0] pat_len [NUM_PATTERNS];

  logic [CNT_W-1:0] pattern_count;
  logic [CNT_W-1:0] active_n;
  logic [ROW_W-1:0] host_window;   // newest byte in the top lane
  logic [LEN_W-1:0] bytes_seen;
  logic             match_flag;

  // compare stage
  logic [ROW_W-1:0]           row_q;
  logic [ROW_W-1:0]           aligned_q;
  logic [MAX_PATTERN_LEN-1:0] mask_q;
  logic                       len_ok_q;
  logic                       cmp_v;

  logic [LEN_W-1:0]           sel_len;
  logic [LEN_W-1:0]           skip;
  logic [MAX_PATTERN_LEN-1:0] sel_mask;
  logic [LEN_W-1:0]           len_sat;
  logic [MAX_PATTERN_LEN-1:0] byte_ok;
  logic                       tail_hit;
  logic                       empty_hit;

  assign active_n     = (pattern_count > CNT_W'(NUM_PATTERNS)) ? CNT_W'(NUM_PATTERNS)
                                                               : pattern_count;
  assign sts.active_n = active_n;

  assign len_sat = (int'(value) > MAX_PATTERN_LEN) ? LEN_W'(MAX_PATTERN_LEN)
                                                   : LEN_W'(value);

  // window tail alignment for the slot being issued
  assign sel_len = pat_len[cmd.slot];
  assign skip    = LEN_W'(MAX_PATTERN_LEN) - sel_len;

  always_comb begin
    for (int k = 0; k < MAX_PATTERN_LEN; k++) begin
      sel_mask[k] = (LEN_W'(k) < sel_len);
    end
  end

  always_comb begin
    for (int k = 0; k < MAX_PATTERN_LEN; k++) begin
      byte_ok[k] = !mask_q[k] ||
                   (row_q[k*BYTE_W +: BYTE_W] == aligned_q[k*BYTE_W +: BYTE_W]);
    end
  end

  assign tail_hit = cmp_v && len_ok_q && (&byte_ok);

  // an active empty pattern matches any host
  always_comb begin
    empty_hit = 1'b0;
    for (int i = 0; i < NUM_PATTERNS; i++) begin
      empty_hit = empty_hit || ((pat_len[i] == '0) && (CNT_W'(i) < active_n));
    end
  end

  // pattern memory, byte-lane write and registered row read
  always_ff @(posedge clk) begin
    if (cmd.wr_byte) begin
      pat_mem[pattern_slot][BYTE_W*char_position +: BYTE_W] <= value;
    end
    if (cmd.issue) begin
      row_q <= pat_mem[cmd.slot];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      aligned_q <= host_window >> (BYTE_W * int'(skip));
      mask_q    <= sel_mask;
      len_ok_q  <= (sel_len <= bytes_seen);
    end
    if (cmd.host_byte) begin
      host_window <= {value, host_window[ROW_W-1:BYTE_W]};
    end
    if (cmd.end_host) begin
      blocked <= match_flag || empty_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_count <= '0;
      bytes_seen    <= '0;
      match_flag    <= 1'b0;
      cmp_v         <= 1'b0;
      for (int i = 0; i < NUM_PATTERNS; i++) begin
        pat_len[i] <= '0;
      end
    end else begin
      cmp_v <= cmd.issue;
      if (cfg_wr_en) begin
        pattern_count <= cfg_wr_data;
      end
      if (cmd.wr_len) begin
        pat_len[pattern_slot] <= len_sat;
      end
      if (cmd.end_host) begin
        bytes_seen <= '0;
        match_flag <= 1'b0;
      end else begin
        if (cmd.host_byte && (bytes_seen < LEN_W'(MAX_PATTERN_LEN))) begin
          bytes_seen <= bytes_seen + LEN_W'(1);
        end
        if (tail_hit) begin
          match_flag <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> sv/hsbm_ctrl.sv
// hsbm_ctrl: handshake and slot scan sequencer for the matcher;
// depends on hsbm_pkg
`default_nettype none

module hsbm_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [hsbm_pkg::CMD_W-1:0]  command,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output hsbm_pkg::dp_cmd_t                cmd,
  input  wire hsbm_pkg::dp_sts_t           sts
);
  import hsbm_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]        state;
  logic [1:0]        state_next;
  logic [SLOT_W-1:0] slot;
  logic [SLOT_W-1:0] slot_next;
  logic              accept;
  logic              last_slot;

  // end of host needs the result register free
  assign in_ready = (state == ST_IDLE) &&
                    ((command != CMD_END_HOST) || !out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  assign cmd.wr_byte   = accept && (command == CMD_WR_BYTE);
  assign cmd.wr_len    = accept && (command == CMD_SET_LEN);
  assign cmd.host_byte = accept && (command == CMD_HOST_BYTE);
  assign cmd.end_host  = accept && (command == CMD_END_HOST);
  assign cmd.issue     = (state == ST_SCAN);
  assign cmd.slot      = slot;

  assign last_slot = ((CNT_W'(slot) + CNT_W'(1)) == sts.active_n);

  always_comb begin
    state_next = state;
    slot_next  = slot;
    unique case (state)
      ST_IDLE: begin
        if (cmd.host_byte && (sts.active_n != '0)) begin
          state_next = ST_SCAN;
          slot_next  = '0;
        end
      end
      ST_SCAN: begin
        if (last_slot) begin
          state_next = ST_DRAIN;
        end else begin
          slot_next = slot + SLOT_W'(1);
        end
      end
      ST_DRAIN: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      slot      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      slot  <= slot_next;
      if (cmd.end_host) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

>>> sv/host_substring_blocklist_matcher_top.sv
// host_substring_blocklist_matcher_top: top level joining controller and
// datapath; depends on hsbm_pkg, hsbm_if, hsbm_ctrl and hsbm_datapath
//
// Flags a host name as blocked when any active pattern occurs anywhere in it.
// Items arrive on a valid/ready channel: command 0 writes one pattern byte,
// command 1 sets a pattern length (lengths above 64 are held as 64), command 2
// streams one host byte, command 3 closes the host and produces one result
// transfer carrying blocked. After a host byte, the host window is compared
// against each active slot (pattern_count, held at 16 at most), one pattern
// slot per cycle with a full 64-byte compare, then a drain state flushes the
// compare stage; no item is taken until the scan is over. With no active slot
// there is no scan. The result waits in an output register, so pattern and
// host items keep flowing while it is not yet taken; only a further end of
// host waits for it. pattern_count is written through cfg_wr_en / cfg_wr_data;
// the user must write it only while the block is idle; the block does not
// enforce this. Pattern bytes have no reset: every byte inside the stored
// length of an active slot must be written before hosts are checked against
// it. An active empty pattern matches every host, including an empty one.
`default_nettype none

module host_substring_blocklist_matcher_top (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_wr_en,
  input  wire logic [hsbm_pkg::CNT_W-1:0] cfg_wr_data,
  hsbm_in_if.sink                         items,
  hsbm_out_if.source                      results
);
  import hsbm_pkg::*;

  // command and status between sequencer and datapath
  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  // handshake, slot scan sequencing and result valid
  hsbm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (items.valid),
    .in_ready  (items.ready),
    .command   (items.command),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .cmd       (dp_cmd),
    .sts       (dp_sts)
  );

  // pattern storage, window, compare stage and result payload
  hsbm_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (dp_cmd),
    .sts           (dp_sts),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .pattern_slot  (items.pattern_slot),
    .char_position (items.char_position),
    .value         (items.value),
    .blocked       (results.blocked)
  );

  // no item transfer while a slot scan is running
  a_no_accept_in_scan: assert property (@(posedge clk) disable iff (rst)
    dp_cmd.issue |-> !(items.valid && items.ready))
    else $error("item transfer during slot scan");

  // scan only visits active slots
  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    dp_cmd.issue |-> (CNT_W'(dp_cmd.slot) < dp_sts.active_n))
    else $error("scan slot beyond active count");

  // at most one datapath command per cycle
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({dp_cmd.wr_byte, dp_cmd.wr_len, dp_cmd.host_byte,
              dp_cmd.end_host, dp_cmd.issue}))
    else $error("overlapping datapath commands");

  // end of host always raises the result valid on the next edge
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    dp_cmd.end_host |=> results.valid)
    else $error("end of host without result");

endmodule

`default_nettype wire

>>> sim/tb_top.sv
// tb_top: self-checking bench for host_substring_blocklist_matcher_top; a directed table,
// then randomized pattern loads and host streams scored by a behavioral verdict model
// depends on hsbm_pkg, hsbm_if and the matcher rtl
`timescale 1ns / 100ps

module tb_top;
  import hsbm_pkg::*;

  localparam int PREDICT      = -1;     // row verdict comes from the model
  localparam int SETTLE_CYC   = 40;     // longer than the worst host byte scan over all 16 slots
  localparam int PHASE_ITEMS  = 80;
  localparam int NUM_PHASES   = 6;
  localparam int MAX_REPORTS  = 40;

  typedef struct {
    logic [CMD_W-1:0]  cmd;
    logic [SLOT_W-1:0] slot;
    logic [POS_W-1:0]  pos;
    logic [BYTE_W-1:0] val;
    int                verdict;
  } stim_row_t;

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [CNT_W-1:0] cfg_wr_data;

  hsbm_in_if  item_ch ();
  hsbm_out_if verdict_ch ();

  host_substring_blocklist_matcher_top u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .items       (item_ch),
    .results     (verdict_ch)
  );

  // ---------------------------------------------------------------------------
  // behavioral copy of the matcher state
  // ---------------------------------------------------------------------------
  logic [BYTE_W-1:0] pat_mem     [NUM_PATTERNS][MAX_PATTERN_LEN];
  bit                pat_written [NUM_PATTERNS][MAX_PATTERN_LEN];
  int                pat_len     [NUM_PATTERNS];
  logic [BYTE_W-1:0] host_win    [MAX_PATTERN_LEN];
  int                host_seen;
  bit                sticky_hit;
  int                active_cfg;

  // verdicts still owed by the block, oldest first
  bit pending_verdicts [$];

  int mismatches;
  int items_sent;
  int verdicts_checked;
  int verdicts_blocked;
  int tx_idle_pct;
  int rx_stall_pct;

  // clock, 8 ns period
  initial clk = 1'b0;
  always #4 clk = ~clk;

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_REPORTS)
      $display("[%0t] MISMATCH: %s", $time, msg);
    mismatches++;
  endtask

  function automatic int active_slots();
    return (active_cfg > NUM_PATTERNS) ? NUM_PATTERNS : active_cfg;
  endfunction

  // leading run of written bytes in a slot; a length never goes past it,
  // so no compare ever touches an unwritten pattern byte
  function automatic int written_prefix(input int slot);
    int n;
    n = 0;
    while (n < MAX_PATTERN_LEN && pat_written[slot][n]) n++;
    return n;
  endfunction

  // window tail against a whole slot
  function automatic bit tail_hit(input int slot);
    int len;
    len = pat_len[slot];
    for (int k = 0; k < len; k++)
      if (pat_mem[slot][k] != host_win[MAX_PATTERN_LEN - len + k]) return 1'b0;
    return 1'b1;
  endfunction

  // advance the model by one item; an end of host yields the verdict
  task automatic step_verdict_model(input logic [CMD_W-1:0] cmd,
                                    input logic [SLOT_W-1:0] slot,
                                    input logic [POS_W-1:0] pos,
                                    input logic [BYTE_W-1:0] val,
                                    output bit gives, output bit verdict);
    int n;
    n = active_slots();
    gives = 1'b0;
    verdict = 1'b0;
    case (cmd)
      CMD_WR_BYTE: begin
        pat_mem[slot][pos] = val;
        pat_written[slot][pos] = 1'b1;
      end
      CMD_SET_LEN: begin
        pat_len[slot] = (val > MAX_PATTERN_LEN) ? MAX_PATTERN_LEN : int'(val);
      end
      CMD_HOST_BYTE: begin
        for (int i = 0; i < MAX_PATTERN_LEN - 1; i++) host_win[i] = host_win[i + 1];
        host_win[MAX_PATTERN_LEN - 1] = val;
        if (host_seen < MAX_PATTERN_LEN) host_seen++;
        for (int s = 0; s < n; s++)
          if (pat_len[s] <= host_seen && tail_hit(s)) sticky_hit = 1'b1;
      end
      CMD_END_HOST: begin
        verdict = sticky_hit;
        // an active empty pattern blocks any host, even an empty one
        for (int s = 0; s < n; s++)
          if (pat_len[s] == 0) verdict = 1'b1;
        gives = 1'b1;
        foreach (host_win[i]) host_win[i] = '0;
        host_seen = 0;
        sticky_hit = 1'b0;
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // item driver: fields change at the falling edge, transfer seen at the rising
  // edge; returns at the falling edge after the transfer with valid still high
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [SLOT_W-1:0] slot,
                           input logic [POS_W-1:0] pos, input logic [BYTE_W-1:0] val,
                           input int verdict = PREDICT);
    bit gives;
    bit model_verdict;
    // random sender gaps, one valid assignment per falling edge
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(negedge clk);
    end
    item_ch.valid         <= 1'b1;
    item_ch.command       <= cmd;
    item_ch.pattern_slot  <= slot;
    item_ch.char_position <= pos;
    item_ch.value         <= val;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    // transfer happened on this edge
    step_verdict_model(cmd, slot, pos, val, gives, model_verdict);
    if (gives)
      pending_verdicts.push_back((verdict == PREDICT) ? model_verdict : verdict[0]);
    items_sent++;
    @(negedge clk);
  endtask

  // drop valid, wait for every owed verdict, then let the block go quiet
  task automatic drain_verdicts(input int extra);
    item_ch.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  // only called with the block idle; starts and ends on a falling edge
  task automatic set_pattern_count(input int count);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= count[CNT_W-1:0];
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    active_cfg = count;
  endtask

  // byte source biased to a small alphabet so hosts and patterns collide often
  function automatic logic [BYTE_W-1:0] pick_byte();
    case ($urandom_range(9))
      0:       return 8'h00;
      1:       return 8'hFF;
      2, 3:    return 8'h61;
      4, 5:    return 8'h62;
      6:       return 8'h2E;
      default: return BYTE_W'($urandom_range(255));
    endcase
  endfunction

  // a length the slot can hold without exposing unwritten bytes
  function automatic logic [BYTE_W-1:0] legal_len(input int slot);
    int p;
    p = written_prefix(slot);
    if (p == MAX_PATTERN_LEN) return BYTE_W'($urandom_range(255));
    return BYTE_W'($urandom_range(p));
  endfunction

  // write bytes 0..len-1 then commit the length; a full slot gets a
  // length value at or above the maximum to exercise the clamp
  task automatic load_pattern(input int slot, input int len);
    for (int k = 0; k < len; k++)
      send_item(CMD_WR_BYTE, SLOT_W'(slot), POS_W'(k), pick_byte());
    send_item(CMD_SET_LEN, SLOT_W'(slot), POS_W'($urandom_range(63)),
              (len == MAX_PATTERN_LEN) ? BYTE_W'($urandom_range(255, 64)) : BYTE_W'(len));
  endtask

  // pattern edits landing between host bytes
  task automatic mid_host_edit();
    int s;
    s = $urandom_range(NUM_PATTERNS - 1);
    if ($urandom_range(1))
      send_item(CMD_SET_LEN, SLOT_W'(s), POS_W'($urandom_range(63)), legal_len(s));
    else
      send_item(CMD_WR_BYTE, SLOT_W'(s), POS_W'($urandom_range(63)), pick_byte());
  endtask

  // one host name: random bytes, often with an active pattern planted inside,
  // mostly short, sometimes longer than the window
  task automatic send_host();
    logic [BYTE_W-1:0] host_q [$];
    int hlen;
    int n;
    int s;
    int at;
    hlen = ($urandom_range(99) < 85) ? $urandom_range(12) : $urandom_range(90, 40);
    for (int i = 0; i < hlen; i++) host_q.push_back(pick_byte());
    n = active_slots();
    if (n > 0 && $urandom_range(1)) begin
      s = $urandom_range(n - 1);
      at = $urandom_range(host_q.size());
      for (int k = 0; k < pat_len[s]; k++) host_q.insert(at + k, pat_mem[s][k]);
    end
    foreach (host_q[i]) begin
      if ($urandom_range(99) < 5) mid_host_edit();
      send_item(CMD_HOST_BYTE, SLOT_W'($urandom_range(15)), POS_W'($urandom_range(63)),
                host_q[i]);
    end
    send_item(CMD_END_HOST, SLOT_W'($urandom_range(15)), POS_W'($urandom_range(63)),
              BYTE_W'($urandom_range(255)));
  endtask

  task automatic run_random_phase(input int count, input int mode);
    int start;
    int roll;
    int s;
    int len;
    bit paused;
    drain_verdicts(SETTLE_CYC);
    set_pattern_count(count);
    // 0: free flow, 1: sender sparse, 2: receiver stalls, 3: light both
    tx_idle_pct  = (mode == 1) ? 82 : (mode == 3) ? 17 : 0;
    rx_stall_pct = (mode == 2) ? 82 : (mode == 3) ? 17 : 0;
    start = items_sent;
    paused = 1'b0;
    while (items_sent - start < PHASE_ITEMS) begin
      // once per phase the sender holds off until all verdicts are back
      if (!paused && items_sent - start >= PHASE_ITEMS / 2) begin
        drain_verdicts(1);
        paused = 1'b1;
      end
      roll = $urandom_range(99);
      s = $urandom_range(NUM_PATTERNS - 1);
      if (roll < 55) begin
        send_host();
      end else if (roll < 75) begin
        roll = $urandom_range(99);
        len = (roll < 10) ? MAX_PATTERN_LEN : (roll < 30) ? $urandom_range(20, 7)
                                                          : $urandom_range(6, 1);
        load_pattern(s, len);
      end else if (roll < 90) begin
        send_item(CMD_SET_LEN, SLOT_W'(s), POS_W'($urandom_range(63)), legal_len(s));
      end else if (roll < 95) begin
        // stray byte write, full field ranges
        send_item(CMD_WR_BYTE, SLOT_W'(s), POS_W'($urandom_range(63)),
                  BYTE_W'($urandom_range(255)));
      end else begin
        send_item(CMD_END_HOST, SLOT_W'(s), POS_W'($urandom_range(63)),
                  BYTE_W'($urandom_range(255)));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // result side: random back-pressure, verdicts scored at the rising edge
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    verdict_ch.ready <= (rx_stall_pct == 0) ? 1'b1 : ($urandom_range(99) >= rx_stall_pct);
  end

  always @(posedge clk) begin
    bit want;
    if (!rst && verdict_ch.valid && verdict_ch.ready) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch($sformatf("verdict transfer blocked=%0b with none owed",
                                  verdict_ch.blocked));
      end else begin
        want = pending_verdicts.pop_front();
        verdicts_checked++;
        if (want) verdicts_blocked++;
        if (verdict_ch.blocked !== want)
          report_mismatch($sformatf("host %0d: blocked=%0b, model says %0b",
                                    verdicts_checked, verdict_ch.blocked, want));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // directed table, walked with pattern_count = 1; typed verdicts where obvious
  // ---------------------------------------------------------------------------
  stim_row_t directed_rows [24] = '{
    // slot 0 starts active and empty: matches everything
    '{CMD_END_HOST,  4'd0,  6'd0,  8'h00, 1},
    '{CMD_HOST_BYTE, 4'd0,  6'd0,  8'h78, PREDICT},
    '{CMD_END_HOST,  4'd0,  6'd0,  8'h00, 1},
    // slot 0 becomes the two bytes 00 ff
    '{CMD_WR_BYTE,   4'd0,  6'd0,  8'h00, PREDICT},
    '{CMD_WR_BYTE,   4'd0,  6'd1,  8'hFF, PREDICT},
    '{CMD_SET_LEN,   4'd0,  6'd0,  8'd2,  PREDICT},
    // empty host no longer matches
    '{CMD_END_HOST,  4'd15, 6'd63, 8'hFF, 0},
    '{CMD_HOST_BYTE, 4'd15, 6'd63, 8'h00, PREDICT},
    '{CMD_HOST_BYTE, 4'd0,  6'd0,  8'hFF, PREDICT},
    '{CMD_END_HOST,  4'd0,  6'd0,  8'h00, 1},
    '{CMD_HOST_BYTE, 4'd0,  6'd0,  8'hFF, PREDICT},
    '{CMD_HOST_BYTE, 4'd0,  6'd0,  8'h00, PREDICT},
    '{CMD_END_HOST,  4'd0,  6'd0,  8'h00, 0},
    // inactive slot 15 at the top position, left empty: no effect
    '{CMD_WR_BYTE,   4'd15, 6'd63, 8'hA5, PREDICT},
    '{CMD_SET_LEN,   4'd15, 6'd0,  8'd0,  PREDICT},
    '{CMD_END_HOST,  4'd0,  6'd0,  8'h00, 0},
    // shrink slot 0 mid-host, only later compares see it
    '{CMD_HOST_BYTE, 4'd0,  6'd0,  8'h00, PREDICT},
    '{CMD_SET_LEN,   4'd0,  6'd0,  8'd1,  PREDICT},
    '{CMD_HOST_BYTE, 4'd0,  6'd0,  8'h11, PREDICT},
    '{CMD_END_HOST,  4'd0,  6'd0,  8'h00, PREDICT},
    '{CMD_HOST_BYTE, 4'd0,  6'd0,  8'hFF, PREDICT},
    '{CMD_HOST_BYTE, 4'd0,  6'd0,  8'h00, PREDICT},
    '{CMD_END_HOST,  4'd0,  6'd0,  8'h00, PREDICT},
    '{CMD_SET_LEN,   4'd0,  6'd0,  8'd2,  PREDICT}
  };

  // pattern_count per random phase: full, overrange max, partial, none, just over, one
  int phase_counts [NUM_PHASES] = '{16, 31, 4, 0, 17, 1};

  initial begin
    int wait_cyc;
    // known values on every input from time zero
    rst                   = 1'b1;
    cfg_wr_en             = 1'b0;
    cfg_wr_data           = '0;
    item_ch.valid         = 1'b0;
    item_ch.command       = CMD_WR_BYTE;
    item_ch.pattern_slot  = '0;
    item_ch.char_position = '0;
    item_ch.value         = '0;
    verdict_ch.ready      = 1'b0;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    mismatches = 0;
    items_sent = 0;
    verdicts_checked = 0;
    verdicts_blocked = 0;
    // model matches the post-reset state
    foreach (pat_mem[s, k]) begin
      pat_mem[s][k] = '0;
      pat_written[s][k] = 1'b0;
    end
    foreach (pat_len[s]) pat_len[s] = 0;
    foreach (host_win[i]) host_win[i] = '0;
    host_seen  = 0;
    sticky_hit = 1'b0;
    active_cfg = 0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    set_pattern_count(1);
    foreach (directed_rows[i])
      send_item(directed_rows[i].cmd, directed_rows[i].slot, directed_rows[i].pos,
                directed_rows[i].val, directed_rows[i].verdict);

    // one full-length slot up front so the length clamp and top positions show up
    load_pattern(1, MAX_PATTERN_LEN);

    for (int p = 0; p < NUM_PHASES; p++)
      run_random_phase(phase_counts[p], p % 4);

    // let the last verdicts come home, bounded
    item_ch.valid <= 1'b0;
    wait_cyc = 0;
    while (pending_verdicts.size() != 0 && wait_cyc < 20000) begin
      @(negedge clk);
      wait_cyc++;
    end
    repeat (SETTLE_CYC) @(negedge clk);
    while (pending_verdicts.size() != 0) begin
      report_mismatch($sformatf("verdict blocked=%0b never arrived",
                                pending_verdicts.pop_front()));
    end

    $display("summary: %0d items driven, %0d host verdicts scored (%0d blocked)",
             items_sent, verdicts_checked, verdicts_blocked);
    $display("summary: pattern_count settings 1,16,31,4,0,17,1 under four flow-control mixes");
    if (mismatches == 0)
      $display("host_substring_blocklist_matcher_top regression: pass");
    else
      $display("host_substring_blocklist_matcher_top regression: fail");
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #4_000_000;
    $display("host_substring_blocklist_matcher_top regression: fail");
    $finish;
  end

endmodule
